// ===== rtl/ida_pkg.sv =====
package ida_pkg;

	localparam int VALUE_W    = 32;
	localparam int CHAR_W     = 7;
	localparam int NUM_DIGITS = 10;
	localparam int DIGIT_W    = 4;
	localparam int BIT_CNT_W  = $clog2(VALUE_W);
	localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

	localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 7'd48;
	localparam logic [CHAR_W-1:0]  ASCII_MINUS = 7'd45;
	localparam logic [DIGIT_W-1:0] DEC_MAX     = 4'd9;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONVERT,
		ST_TRIM,
		ST_DIGITS
	} ida_state_t;

	// Command shared by every cell of the digit row.
	typedef struct packed {
		logic clear;
		logic dabble;
		logic shift;
	} ida_cell_ctrl_t;

endpackage

// ===== rtl/int_to_decimal_ascii_core.sv =====
// Signed 32-bit integer to decimal ASCII text.
//
// A request is taken at a rising edge with start high and busy low; value is
// sampled then. The block answers with one character per strobe, most
// significant first: a minus sign for a negative value, then the decimal
// digits with no leading zeros ('0' alone for zero). last marks the final
// character of the number. Each character is on character/last for exactly
// one cycle with strobe high; the receiver cannot stall the block, so
// strobes come back to back once the first one appears.
//
// Operation: the magnitude is fed one bit a cycle into a row of ten BCD digit
// cells (shift and add three). The row then shifts toward its top cell once a
// cycle, first past the leading zeros and then out through the output
// register. A negative value keeps busy high longer than a non-negative one,
// for its minus sign; a new request may be taken in the cycle that the last
// character is on the ports.
//
// Reset clears the sequencer and the strobe; nothing else needs clearing.
module int_to_decimal_ascii_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [ida_pkg::VALUE_W-1:0]  value,
	output logic                                strobe,
	output logic [ida_pkg::CHAR_W-1:0]          character,
	output logic                                last
);
	import ida_pkg::*;

	ida_state_t             state_q, state_d;
	logic [BIT_CNT_W-1:0]   bit_cnt_q;
	logic [DIG_CNT_W-1:0]   ndig_q, ndig_d;
	logic [VALUE_W-1:0]     mag_q;
	logic                   neg_q;
	logic                   strobe_q, strobe_d;
	logic [CHAR_W-1:0]      character_q, character_d;
	logic                   last_q, last_d;
	logic                   load;
	ida_cell_ctrl_t         ctrl;

	logic [VALUE_W-1:0]     value_u;
	logic [VALUE_W-1:0]     mag_in;
	logic [DIGIT_W-1:0]     digits [NUM_DIGITS];
	logic                   carry  [NUM_DIGITS];
	logic [DIGIT_W-1:0]     top_digit;
	logic [CHAR_W-1:0]      top_char;

	assign value_u   = value;
	assign mag_in    = value[VALUE_W-1] ? ({VALUE_W{1'b0}} - value_u) : value_u;
	assign top_digit = digits[NUM_DIGITS-1];
	assign top_char  = ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, top_digit};

	genvar gi;
	generate
		for (gi = 0; gi < NUM_DIGITS; gi++) begin : g_cell
			logic                bit_link;
			logic [DIGIT_W-1:0]  dig_link;
			if (gi == 0) begin : g_first
				assign bit_link = mag_q[VALUE_W-1];
				assign dig_link = '0;
			end else begin : g_rest
				assign bit_link = carry[gi-1];
				assign dig_link = digits[gi-1];
			end
			ida_digit_cell u_cell (
				.clk       (clk),
				.ctrl      (ctrl),
				.bit_in    (bit_link),
				.dig_in    (dig_link),
				.carry_out (carry[gi]),
				.digit     (digits[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			bit_cnt_q <= '0;
			ndig_q    <= '0;
			strobe_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			ndig_q   <= ndig_d;
			strobe_q <= strobe_d;
			if (load) begin
				bit_cnt_q <= BIT_CNT_W'(VALUE_W - 1);
			end else if (state_q == ST_CONVERT) begin
				bit_cnt_q <= bit_cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			mag_q <= mag_in;
			neg_q <= value[VALUE_W-1];
		end else if (state_q == ST_CONVERT) begin
			mag_q <= {mag_q[VALUE_W-2:0], 1'b0};
		end
		character_q <= character_d;
		last_q      <= last_d;
	end

	always_comb begin
		state_d     = state_q;
		ndig_d      = ndig_q;
		load        = 1'b0;
		ctrl        = '0;
		strobe_d    = 1'b0;
		character_d = top_char;
		last_d      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					load       = 1'b1;
					ctrl.clear = 1'b1;
					ndig_d     = DIG_CNT_W'(NUM_DIGITS);
					state_d    = ST_CONVERT;
				end
			end
			ST_CONVERT: begin
				ctrl.dabble = 1'b1;
				if (bit_cnt_q == '0) begin
					state_d = ST_TRIM;
				end
			end
			ST_TRIM: begin
				if (top_digit == '0 && ndig_q > 1) begin
					ctrl.shift = 1'b1;
					ndig_d     = ndig_q - 1'b1;
				end else if (neg_q) begin
					strobe_d    = 1'b1;
					character_d = ASCII_MINUS;
					state_d     = ST_DIGITS;
				end else begin
					strobe_d   = 1'b1;
					last_d     = (ndig_q == 1);
					ctrl.shift = 1'b1;
					ndig_d     = ndig_q - 1'b1;
					state_d    = (ndig_q == 1) ? ST_IDLE : ST_DIGITS;
				end
			end
			ST_DIGITS: begin
				strobe_d   = 1'b1;
				last_d     = (ndig_q == 1);
				ctrl.shift = 1'b1;
				ndig_d     = ndig_q - 1'b1;
				if (ndig_q == 1) begin
					state_d = ST_IDLE;
				end
			end
		endcase
	end

	assign busy      = (state_q != ST_IDLE);
	assign strobe    = strobe_q;
	assign character = character_q;
	assign last      = last_q;

`ifndef NO_ASSERTIONS
	// Ten digits hold any 32-bit magnitude, so the top cell never overflows.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CONVERT |-> !carry[NUM_DIGITS-1])
		else $error("digit row overflowed during conversion");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TRIM || state_q == ST_DIGITS) |-> top_digit <= DEC_MAX)
		else $error("top digit cell holds a non-decimal code");

	a_char_code: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (character == ASCII_MINUS ||
			(character >= ASCII_ZERO && character <= ASCII_ZERO + 7'd9)))
		else $error("strobed character is neither a digit nor a minus sign");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> !busy)
		else $error("block still busy after the final character");

	a_more_follows: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy)
		else $error("request ended without a final character");
`endif

endmodule

// ===== rtl/ida_digit_cell.sv =====
module ida_digit_cell (
	input  logic                         clk,
	input  ida_pkg::ida_cell_ctrl_t      ctrl,
	input  logic                         bit_in,
	input  logic [ida_pkg::DIGIT_W-1:0]  dig_in,
	output logic                         carry_out,
	output logic [ida_pkg::DIGIT_W-1:0]  digit
);
	import ida_pkg::*;

	logic [DIGIT_W-1:0] digit_q;
	logic [DIGIT_W-1:0] adj;

	// A digit of five or more becomes ten or more after the doubling,
	// so add three first and let bit three spill into the next cell.
	always_comb begin
		adj = (digit_q > 4'd4) ? (digit_q + 4'd3) : digit_q;
	end

	assign carry_out = adj[DIGIT_W-1];
	assign digit     = digit_q;

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			digit_q <= '0;
		end else if (ctrl.dabble) begin
			digit_q <= {adj[DIGIT_W-2:0], bit_in};
		end else if (ctrl.shift) begin
			digit_q <= dig_in;
		end
	end

endmodule
